FILE: design/nrba_pkg.sv
// ----------------------------------------------------------------------------
// nrba_pkg: shared types and codes of the named region bump allocator
// Function and status codes, register indexes and the structs that move
// between the table cells and the control logic.
// ----------------------------------------------------------------------------
`default_nettype none

package nrba_pkg;

	// function codes of an input item
	localparam logic [1:0] FN_ALLOC  = 2'd0;
	localparam logic [1:0] FN_LOOKUP = 2'd1;
	localparam logic [1:0] FN_CLEAR  = 2'd2;

	// result status codes
	localparam logic [2:0] STAT_NEW      = 3'd0;
	localparam logic [2:0] STAT_SHARED   = 3'd1;
	localparam logic [2:0] STAT_NOTFOUND = 3'd2;
	localparam logic [2:0] STAT_OOM      = 3'd3;
	localparam logic [2:0] STAT_INVALID  = 3'd4;

	// configuration register indexes
	localparam logic REG_BASE = 1'b0;
	localparam logic REG_SIZE = 1'b1;

	// page rounding
	localparam logic [32:0] PAGE_MASK  = 33'h0_0000_0FFF;
	localparam logic [31:0] STORED_CAP = 32'hFFFF_F000;

	// search item travelling down the row of cells
	typedef struct packed {
		logic        valid;
		logic [63:0] key;
		logic        hit;
		logic [31:0] start;
		logic [31:0] length;
	} token_t;

	// append write broadcast to the cells
	typedef struct packed {
		logic        en;
		logic [63:0] key;
		logic [31:0] start;
		logic [31:0] length;
	} wr_t;

endpackage

`default_nettype wire

FILE: design/named_region_bump_allocator_unit.sv
// ----------------------------------------------------------------------------
// named_region_bump_allocator_unit: table of named regions in one memory area
// Allocates page-rounded regions in order after a header block, shares a
// region among requests with the same owner key, looks keys up and clears.
// ----------------------------------------------------------------------------
// Timing: one item at a time. A look-up or an allocate sends its key down a
// row of MAX_ENTRIES table cells, one cell per cycle; a clear or a rejected
// item skips the row. A new item is taken once the previous result has moved
// into the output register, even while that result still waits on a stall.
// No clearing pass after reset.
`default_nettype none

module named_region_bump_allocator_unit #(
	parameter int MAX_ENTRIES  = 64,
	parameter int HEADER_BYTES = 32768
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_wdata,
	// input items
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [63:0] owner_key,
	input  wire logic [31:0] request_length,
	// result items
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [31:0]      region_start,
	output logic [31:0]      region_length
);

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SEARCH = 3'b010,
		S_RESP   = 3'b100
	} state_t;

	state_t      state_q;
	logic [31:0] base_q;
	logic [31:0] size_q;
	logic [CW-1:0] count_q;
	logic [32:0] used_q;

	logic [1:0]  func_q;
	logic [63:0] key_q;
	logic [31:0] len_q;
	logic        launch_valid_q;
	logic [33:0] need_q;
	logic [31:0] start_calc_q;
	logic [32:0] rounded_q;

	logic [2:0]  res_status_q;
	logic [31:0] res_start_q;
	logic [31:0] res_len_q;
	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [31:0] out_start_q;
	logic [31:0] out_len_q;

	logic        in_acc;
	logic        launch;
	logic        chain_done;
	logic        alloc_ok;
	logic        resp_load;
	logic [31:0] stored_len;

	nrba_pkg::token_t tok [MAX_ENTRIES+1];
	nrba_pkg::wr_t    wr;

	assign in_stall   = (state_q != S_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign chain_done = tok[MAX_ENTRIES].valid;
	assign resp_load  = (state_q == S_RESP) && (!out_valid_q || !out_stall);

	// valid look-up or allocate that needs a search
	assign launch = in_acc && (owner_key != '0)
		&& (func == nrba_pkg::FN_LOOKUP
		|| (func == nrba_pkg::FN_ALLOC && request_length != '0));

	// room check and table space for a new region
	assign alloc_ok = !tok[MAX_ENTRIES].hit && (func_q == nrba_pkg::FN_ALLOC)
		&& !(need_q > {2'b00, size_q}) && (count_q < CW'(MAX_ENTRIES));
	assign stored_len = rounded_q[32] ? nrba_pkg::STORED_CAP : rounded_q[31:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			size_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				nrba_pkg::REG_BASE: base_q <= cfg_wdata;
				nrba_pkg::REG_SIZE: size_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// launch of the search item into the first cell
	always_comb begin
		tok[0].valid  = launch_valid_q;
		tok[0].key    = key_q;
		tok[0].hit    = 1'b0;
		tok[0].start  = '0;
		tok[0].length = '0;
	end

	// append write to the cell at the fill count
	always_comb begin
		wr.en     = (state_q == S_SEARCH) && chain_done && alloc_ok;
		wr.key    = key_q;
		wr.start  = start_calc_q;
		wr.length = stored_len;
	end

	// row of table cells
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		nrba_cell #(
			.INDEX(i),
			.CW   (CW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.count  (count_q),
			.wr     (wr),
			.tok_in (tok[i]),
			.tok_out(tok[i+1])
		);
	end

	// item fields and sums prepared while the search runs
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q <= func;
			key_q  <= owner_key;
			len_q  <= request_length;
		end
		need_q       <= 34'(HEADER_BYTES) + {1'b0, used_q} + {2'b00, len_q};
		start_calc_q <= base_q + 32'(HEADER_BYTES) + used_q[31:0];
		rounded_q    <= ({1'b0, len_q} + nrba_pkg::PAGE_MASK) & ~nrba_pkg::PAGE_MASK;
	end

	// control sequencer, fill count and used bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			used_q         <= '0;
			launch_valid_q <= 1'b0;
		end else begin
			launch_valid_q <= launch;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (func == nrba_pkg::FN_CLEAR) begin
							count_q <= '0;
							used_q  <= '0;
							state_q <= S_RESP;
						end else if (launch) begin
							state_q <= S_SEARCH;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_SEARCH: begin
					if (chain_done) begin
						if (alloc_ok) begin
							count_q <= count_q + CW'(1);
							used_q  <= used_q + rounded_q;
						end
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (resp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// pending result of the current item
	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_start_q <= '0;
			res_len_q   <= '0;
			if (func == nrba_pkg::FN_CLEAR) begin
				res_status_q <= nrba_pkg::STAT_NEW;
			end else begin
				res_status_q <= nrba_pkg::STAT_INVALID;
			end
		end else if (state_q == S_SEARCH && chain_done) begin
			if (tok[MAX_ENTRIES].hit) begin
				res_status_q <= nrba_pkg::STAT_SHARED;
				res_start_q  <= tok[MAX_ENTRIES].start;
				res_len_q    <= tok[MAX_ENTRIES].length;
			end else if (func_q == nrba_pkg::FN_LOOKUP) begin
				res_status_q <= nrba_pkg::STAT_NOTFOUND;
			end else if (alloc_ok) begin
				res_status_q <= nrba_pkg::STAT_NEW;
				res_start_q  <= start_calc_q;
				res_len_q    <= stored_len;
			end else begin
				res_status_q <= nrba_pkg::STAT_OOM;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_load) begin
			out_status_q <= res_status_q;
			out_start_q  <= res_start_q;
			out_len_q    <= res_len_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign region_start  = out_start_q;
	assign region_length = out_len_q;

	// search item leaves the row only while the sequencer waits for it
	a_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		chain_done |-> state_q == S_SEARCH)
		else $error("search item left the cell row outside a search");

	// an item enters the row only at the start of a search
	a_launch_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		launch_valid_q |-> state_q == S_SEARCH && !chain_done)
		else $error("search item launched outside a search");

	// fill count never passes the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("fill count beyond table depth");

	// an append adds exactly one entry
	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> count_q == $past(count_q) + CW'(1))
		else $error("append did not advance the fill count");

endmodule

`default_nettype wire

FILE: design/nrba_cell.sv
// ----------------------------------------------------------------------------
// nrba_cell: one entry of the region table
// Holds one key, start and length, compares the passing search item against
// its entry and hands the item on to the next cell through a register.
// ----------------------------------------------------------------------------
`default_nettype none

module nrba_cell #(
	parameter int INDEX = 0,
	parameter int CW    = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [CW-1:0]     count,
	input  wire nrba_pkg::wr_t     wr,
	input  wire nrba_pkg::token_t  tok_in,
	output nrba_pkg::token_t       tok_out
);

	logic [63:0] key_q;
	logic [31:0] start_q;
	logic [31:0] length_q;
	logic        occupied;
	logic        match;
	logic        tok_valid_q;
	nrba_pkg::token_t tok_q;

	// entry is live when it lies below the fill count
	assign occupied = CW'(INDEX) < count;
	assign match    = occupied && !tok_in.hit && (key_q == tok_in.key);

	// entry storage, written by an append at this index
	always_ff @(posedge clk) begin
		if (wr.en && (count == CW'(INDEX))) begin
			key_q    <= wr.key;
			start_q  <= wr.start;
			length_q <= wr.length;
		end
	end

	// item valid moves on every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in.valid;
		end
	end

	// item payload, first hit captures this entry
	always_ff @(posedge clk) begin
		if (match) begin
			tok_q <= '{valid: tok_in.valid, key: tok_in.key, hit: 1'b1,
				start: start_q, length: length_q};
		end else begin
			tok_q <= tok_in;
		end
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = tok_valid_q;
	end

endmodule

`default_nettype wire

FILE: tb/named_region_bump_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// named_region_bump_allocator_unit_tb: self-checking bench of the region allocator
// Sends allocate, look-up, clear and unknown items through the valid/stall
// input channel and predicts every result with a model of the region table
// that the bench keeps itself. Results are checked field by field in order.
// Directed items cover rejects, sharing, page rounding, the exact fit, out of
// space and address wrap. Random traffic then runs under changing areas and
// idle patterns, filling and clearing the table.
// ----------------------------------------------------------------------------

module named_region_bump_allocator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nrba_pkg::*;

	localparam int MAX_ENTRIES    = 64;
	localparam int HEADER_BYTES   = 32768;
	localparam int TAIL_CYCLES    = MAX_ENTRIES + 16;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int KEY_POOL       = 72;
	localparam int CHUNKS         = 16;
	localparam int CHUNK_ITEMS    = 109;

	// function code the block does not know
	localparam logic [1:0] FN_UNKNOWN = 2'd3;

	typedef enum int {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] start;
		logic [31:0] length;
	} grant_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        cfg_we         = 1'b0;
	logic        cfg_index      = REG_BASE;
	logic [31:0] cfg_wdata      = '0;
	logic        in_valid       = 1'b0;
	logic        in_stall;
	logic [1:0]  func           = FN_CLEAR;
	logic [63:0] owner_key      = '0;
	logic [31:0] request_length = '0;
	logic        out_valid;
	logic        out_stall      = 1'b0;
	logic [2:0]  status;
	logic [31:0] region_start;
	logic [31:0] region_length;

	// pacing of both channels, in percent per cycle
	int gap_pct   = 0;
	int stall_pct = 0;
	int errors    = 0;

	// predicted table and area
	logic [31:0] area_base = '0;
	logic [31:0] area_size = '0;
	logic [63:0] tbl_key   [MAX_ENTRIES];
	logic [31:0] tbl_start [MAX_ENTRIES];
	logic [31:0] tbl_len   [MAX_ENTRIES];
	int          ent_count = 0;
	logic [32:0] used      = '0;

	grant_t grants_due [$];
	grant_t want;

	named_region_bump_allocator_unit #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.HEADER_BYTES(HEADER_BYTES)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.owner_key     (owner_key),
		.request_length(request_length),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.region_start  (region_start),
		.region_length (region_length)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// expected grant of one item, advances the predicted table
	function automatic grant_t predict_grant(logic [1:0] f, logic [63:0] key, logic [31:0] len);
		grant_t      g;
		int          slot;
		int          i;
		logic [63:0] need;
		logic [32:0] rounded;
		g = '{status: STAT_INVALID, start: '0, length: '0};
		slot = -1;
		for (i = 0; i < ent_count; i++) begin
			if (slot < 0 && tbl_key[i] == key)
				slot = i;
		end
		case (f)
			FN_CLEAR: begin
				ent_count = 0;
				used      = '0;
				g.status  = STAT_NEW;
			end
			FN_LOOKUP: if (key != '0) begin
				if (slot >= 0)
					g = '{status: STAT_SHARED, start: tbl_start[slot], length: tbl_len[slot]};
				else
					g.status = STAT_NOTFOUND;
			end
			FN_ALLOC: if (key != '0 && len != '0) begin
				if (slot >= 0) begin
					g = '{status: STAT_SHARED, start: tbl_start[slot], length: tbl_len[slot]};
				end else begin
					// space check without wrap
					need = 64'(HEADER_BYTES) + 64'(used) + 64'(len);
					if (need > 64'(area_size) || ent_count >= MAX_ENTRIES) begin
						g.status = STAT_OOM;
					end else begin
						rounded  = ({1'b0, len} + PAGE_MASK) & ~PAGE_MASK;
						g.status = STAT_NEW;
						g.start  = area_base + 32'(HEADER_BYTES) + used[31:0];
						g.length = rounded[32] ? STORED_CAP : rounded[31:0];
						tbl_key[ent_count]   = key;
						tbl_start[ent_count] = g.start;
						tbl_len[ent_count]   = g.length;
						ent_count++;
						used = used + rounded;
					end
				end
			end
			default: ;
		endcase
		return g;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, exp_val);
		errors++;
	endtask

	task automatic set_pace(pace_t p);
		case (p)
			PACE_FULL:       begin gap_pct = 0;  stall_pct = 0;  end
			PACE_SEND_IDLE:  begin gap_pct = 78; stall_pct = 0;  end
			PACE_RECV_STALL: begin gap_pct = 0;  stall_pct = 78; end
			default:         begin gap_pct = 13; stall_pct = 13; end
		endcase
	endtask

	// send one item, then record its expected grant once taken
	task automatic send_item(logic [1:0] f, logic [63:0] k, logic [31:0] l);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		func           <= f;
		owner_key      <= k;
		request_length <= l;
		do @(posedge clk); while (in_stall);
		grants_due.push_back(predict_grant(f, k, l));
	endtask

	// drop valid and wait for every outstanding result
	task automatic settle();
		in_valid <= 1'b0;
		while (grants_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write both area registers while the block is idle
	task automatic set_area(logic [31:0] base, logic [31:0] size);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_BASE;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_index <= REG_SIZE;
		cfg_wdata <= size;
		@(posedge clk);
		cfg_we <= 1'b0;
		area_base = base;
		area_size = size;
		@(posedge clk);
	endtask

	// rejects, sharing, rounding, exact fit, out of space and clear
	task automatic test_basic_alloc();
		set_pace(PACE_FULL);
		set_area(32'h1000_0000, 32'h0010_0000);
		send_item(FN_UNKNOWN, 64'h0123_4567_89AB_CDEF, 32'h0000_1000);
		send_item(FN_LOOKUP, '0, 32'h0000_0010);
		send_item(FN_ALLOC, '0, 32'h0000_0010);
		send_item(FN_ALLOC, 64'h0000_0000_0000_00A1, '0);
		send_item(FN_LOOKUP, 64'h0000_0000_0000_00A1, '0);
		send_item(FN_ALLOC, 64'h0000_0000_0000_00A1, 32'h0000_0001);
		send_item(FN_ALLOC, 64'h0000_0000_0000_00A1, 32'h0000_0064);
		send_item(FN_LOOKUP, 64'h0000_0000_0000_00A1, '0);
		send_item(FN_ALLOC, 64'h8000_0000_0000_00B2, 32'h0000_1000);
		send_item(FN_ALLOC, 64'h0000_0000_C300_0000, 32'h0000_1001);
		send_item(FN_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_3000);
		send_item(FN_ALLOC, 64'h0000_0000_0000_00D4, 32'hFFFF_FFFF);
		// fill the rest of the area exactly
		send_item(FN_ALLOC, 64'h0000_0000_0000_00E5,
			area_size - 32'(HEADER_BYTES) - used[31:0]);
		send_item(FN_ALLOC, 64'h0000_0000_0000_00F6, 32'h0000_0001);
		send_item(FN_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_item(FN_LOOKUP, 64'h0000_0000_0000_00A1, '0);
		send_item(FN_ALLOC, 64'h0000_0000_0000_00A1, 32'h0000_0001);
	endtask

	// start address wrap, largest area, empty area and an area one byte past the header
	task automatic test_area_edges();
		set_pace(PACE_BOTH);
		set_area(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(FN_CLEAR, '0, '0);
		send_item(FN_ALLOC, 64'h0000_0000_0000_0011, 32'hFFFF_0000);
		send_item(FN_ALLOC, 64'h0000_0000_0000_0011, 32'hFFFE_0000);
		send_item(FN_ALLOC, 64'h0000_0000_0000_0022, 32'h0001_7FFF);
		send_item(FN_ALLOC, 64'h0000_0000_0000_0033, 32'h0000_0001);
		send_item(FN_LOOKUP, 64'h0000_0000_0000_0022, '0);
		set_area(32'h0000_0000, 32'h0000_0000);
		send_item(FN_CLEAR, '0, '0);
		send_item(FN_ALLOC, 64'h0000_0000_0000_0044, 32'h0000_0001);
		set_area(32'h0000_0000, 32'(HEADER_BYTES + 1));
		send_item(FN_ALLOC, 64'h0000_0000_0000_0055, 32'h0000_0001);
		send_item(FN_ALLOC, 64'h0000_0000_0000_0066, 32'h0000_0001);
	endtask

	// random traffic: shared keys, fresh keys, rejects and clears
	task automatic test_random_traffic();
		logic [63:0] pool [KEY_POOL];
		logic [63:0] k;
		logic [31:0] l;
		logic [31:0] base;
		logic [31:0] size;
		logic [1:0]  f;
		int          clear_pct;
		int          r;
		int          c;
		int          n;
		for (n = 0; n < KEY_POOL; n++)
			pool[n] = {$urandom(), $urandom()} | 64'h1;
		for (c = 0; c < CHUNKS; c++) begin
			set_pace(pace_t'(c % 4));
			case ($urandom_range(2))
				0:       base = '0;
				1:       base = 32'hFFFF_FFFF;
				default: base = $urandom();
			endcase
			case ($urandom_range(5))
				0:       size = $urandom();
				1:       size = 32'(HEADER_BYTES) + 32'($urandom_range(64)) * 32'h1000
					+ 32'($urandom_range(32'hFFF));
				2:       size = 32'($urandom_range(HEADER_BYTES));
				default: size = 32'hFFFF_FFFF;
			endcase
			set_area(base, size);
			case ($urandom_range(2))
				0:       clear_pct = 0;
				1:       clear_pct = 1;
				default: clear_pct = 5;
			endcase
			for (n = 0; n < CHUNK_ITEMS; n++) begin
				r = $urandom_range(99);
				if (r < clear_pct)
					f = FN_CLEAR;
				else if (r < clear_pct + 3)
					f = FN_UNKNOWN;
				else if (r < 35)
					f = FN_LOOKUP;
				else
					f = FN_ALLOC;
				r = $urandom_range(99);
				if (r < 3)
					k = '0;
				else if (r < 50)
					k = pool[$urandom_range(KEY_POOL - 1)];
				else
					k = {$urandom(), $urandom()};
				case ($urandom_range(9))
					0:       l = $urandom();
					1:       l = '0;
					2:       l = {20'($urandom_range(15)), 12'h000} + 32'($urandom_range(1));
					default: l = 32'($urandom_range(1, 32'h4000));
				endcase
				send_item(f, k, l);
			end
		end
	endtask

	// receiver stall
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// result check against the oldest expected grant
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (grants_due.size() == 0) begin
				report_mismatch("result with nothing expected, status", 64'(status), '0);
			end else begin
				want = grants_due.pop_front();
				if (status !== want.status)
					report_mismatch("status", 64'(status), 64'(want.status));
				if (region_start !== want.start)
					report_mismatch("region_start", 64'(region_start), 64'(want.start));
				if (region_length !== want.length)
					report_mismatch("region_length", 64'(region_length), 64'(want.length));
			end
		end
	end

	// watchdog on cycles with no item moving
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// test sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_alloc();
		test_area_edges();
		test_random_traffic();
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && grants_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
design/nrba_pkg.sv
design/nrba_cell.sv
design/named_region_bump_allocator_unit.sv
tb/named_region_bump_allocator_unit_tb.sv
